>>> rtl/core/spd3_pkg.sv
package spd3_pkg;

   localparam int COORD_W    = 32;
   localparam int PARAM_BITS = 16;
   localparam int DIST_W     = 32;

   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int HALF_W  = DOT_W / 2;
   localparam int MAG_W   = 2 * HALF_W;
   localparam int WIDE_W  = 2 * MAG_W;
   localparam int BIG_W   = WIDE_W + 2;
   localparam int QUO_W   = PARAM_BITS + 1;
   localparam int CMP_W   = DIFF_W + PARAM_BITS + 2;
   localparam int CH_W    = CMP_W / 2;
   localparam int CM_W    = 2 * CH_W;
   localparam int SQ_W    = 2 * CM_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = DIST_W;
   localparam int RAD_W   = 2 * DIST_W;
   localparam int SAT_LSB = 2 * PARAM_BITS + RAD_W;

   localparam int FRONT_STAGES = 9;
   localparam int E_STAGES     = 7;

   localparam int NUM_DOTS  = 5;
   localparam int NUM_PRODS = 6;
   localparam int DOT_A11   = 0;
   localparam int DOT_D     = 1;
   localparam int DOT_CC    = 2;
   localparam int DOT_B1    = 3;
   localparam int DOT_B2    = 4;

   localparam int PROD_OPA [NUM_PRODS] = '{DOT_D, DOT_A11, DOT_D, DOT_CC, DOT_A11, DOT_D};
   localparam int PROD_OPB [NUM_PRODS] = '{DOT_D, DOT_CC, DOT_B2, DOT_B1, DOT_B2, DOT_B1};

   localparam logic [1:0] CLS_ZERO = 2'd0;
   localparam logic [1:0] CLS_ONE  = 2'd1;
   localparam logic [1:0] CLS_DIV  = 2'd2;

   typedef logic [DIFF_W-1:0] diff_type;

   typedef struct packed {
      diff_type [2:0] p1;
      diff_type [2:0] p2;
      diff_type [2:0] w;
   } geom_type;

   typedef struct packed {
      logic                             par;
      logic [1:0][1:0]                  cls;
      logic [BIG_W-1:0]                 den;
      logic [1:0][BIG_W-1:0]            rem;
      logic [1:0][PARAM_BITS-1:0]       quo;
      geom_type                         geo;
   } div_type;

   typedef struct packed {
      logic [QUO_W-1:0] u;
      logic [QUO_W-1:0] v;
      logic             par;
   } tag_type;

   typedef struct packed {
      logic             sat;
      logic [RAD_W-1:0] rad;
      logic [RAD_W-1:0] root;
      tag_type          tag;
   } root_type;

endpackage

>>> rtl/core/segment_pair_distance_3d.sv
// Closest distance between two 3D segments given as signed Q16.16 end points. The block
// solves for the closest-point parameters of the two lines, clamps each to [0,1] on its
// own, and returns the distance between the two points (Q16.16, saturating) with both
// parameters in Q1.16; when the determinant is zero both parameters are 0 and
// lines_parallel is set. It is a fixed 66-stage pipeline that takes one beat per cycle
// while the response is not stalled; its stages hold the 16 restoring divide steps on the
// 138-bit determinant and the 32 square-root steps. A stalled response holds the whole
// pipeline.
module segment_pair_distance_3d import spd3_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_seg_a_start_x,
   input  logic signed [COORD_W-1:0]  req_seg_a_start_y,
   input  logic signed [COORD_W-1:0]  req_seg_a_start_z,
   input  logic signed [COORD_W-1:0]  req_seg_a_end_x,
   input  logic signed [COORD_W-1:0]  req_seg_a_end_y,
   input  logic signed [COORD_W-1:0]  req_seg_a_end_z,
   input  logic signed [COORD_W-1:0]  req_seg_b_start_x,
   input  logic signed [COORD_W-1:0]  req_seg_b_start_y,
   input  logic signed [COORD_W-1:0]  req_seg_b_start_z,
   input  logic signed [COORD_W-1:0]  req_seg_b_end_x,
   input  logic signed [COORD_W-1:0]  req_seg_b_end_y,
   input  logic signed [COORD_W-1:0]  req_seg_b_end_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DIST_W-1:0]          rsp_gap_distance,
   output logic [QUO_W-1:0]           rsp_param_on_a,
   output logic [QUO_W-1:0]           rsp_param_on_b,
   output logic                       rsp_lines_parallel,
   output logic                       rsp_distance_saturated
);

   logic en;

   logic signed [COORD_W-1:0] sa [3];
   logic signed [COORD_W-1:0] ea [3];
   logic signed [COORD_W-1:0] sb [3];
   logic signed [COORD_W-1:0] eb [3];

   logic [FRONT_STAGES-1:0] fv_ff, fv_in;
   geom_type g_ff [FRONT_STAGES];
   geom_type g_in [FRONT_STAGES];

   logic signed [PROD_W-1:0] prod_ff [NUM_DOTS][3];
   logic signed [PROD_W-1:0] prod_in [NUM_DOTS][3];
   logic signed [DOT_W-1:0]  dot_ff [NUM_DOTS];
   logic signed [DOT_W-1:0]  dot_in [NUM_DOTS];
   logic [MAG_W-1:0]         mag_ff [NUM_DOTS];
   logic [MAG_W-1:0]         mag_in [NUM_DOTS];
   logic [NUM_DOTS-1:0]      dneg_ff, dneg_in;
   logic [MAG_W-1:0]         pp_ff [NUM_PRODS][4];
   logic [MAG_W-1:0]         pp_in [NUM_PRODS][4];
   logic [NUM_PRODS-1:0]     pneg5_ff, pneg5_in, pneg6_ff, pneg6_in;
   logic [WIDE_W-1:0]        wide_ff [NUM_PRODS];
   logic [WIDE_W-1:0]        wide_in [NUM_PRODS];
   logic signed [BIG_W-1:0]  sp_ff [NUM_PRODS];
   logic signed [BIG_W-1:0]  sp_in [NUM_PRODS];
   logic signed [BIG_W-1:0]  det_ff, det_in;
   logic signed [BIG_W-1:0]  num_ff [2];
   logic signed [BIG_W-1:0]  num_in [2];
   logic                     par9_ff, par9_in;
   logic [BIG_W-1:0]         den9_ff, den9_in;
   logic signed [BIG_W-1:0]  nun_ff [2];
   logic signed [BIG_W-1:0]  nun_in [2];

   div_type              dv_ff [PARAM_BITS+1];
   div_type              dv_in [PARAM_BITS+1];
   logic [PARAM_BITS:0]  dvv_ff, dvv_in;

   logic [E_STAGES-1:0]     ev_ff, ev_in;
   tag_type                 et_ff [E_STAGES];
   tag_type                 et_in [E_STAGES];
   geom_type                e0_geo_ff, e0_geo_in;
   logic signed [CMP_W-1:0] mv_ff [3];
   logic signed [CMP_W-1:0] mv_in [3];
   logic signed [CMP_W-1:0] mu_ff [3];
   logic signed [CMP_W-1:0] mu_in [3];
   diff_type                e1_w_ff [3];
   diff_type                e1_w_in [3];
   logic signed [CMP_W-1:0] comp_ff [3];
   logic signed [CMP_W-1:0] comp_in [3];
   logic [CM_W-1:0]         cmag_ff [3];
   logic [CM_W-1:0]         cmag_in [3];
   logic [CM_W-1:0]         sll_ff [3];
   logic [CM_W-1:0]         sll_in [3];
   logic [CM_W-1:0]         slh_ff [3];
   logic [CM_W-1:0]         slh_in [3];
   logic [CM_W-1:0]         shh_ff [3];
   logic [CM_W-1:0]         shh_in [3];
   logic [SQ_W-1:0]         sq_ff [3];
   logic [SQ_W-1:0]         sq_in [3];
   logic [SUM_W-1:0]        sum_ff, sum_in;

   root_type            rt_ff [ROOT_W];
   root_type            rt_in [ROOT_W];
   logic [ROOT_W-1:0]   sv_ff, sv_in;

   logic                out_vld_ff;
   logic [DIST_W-1:0]   out_dist_ff, out_dist_in;
   logic [QUO_W-1:0]    out_u_ff, out_u_in;
   logic [QUO_W-1:0]    out_v_ff, out_v_in;
   logic                out_par_ff, out_par_in;
   logic                out_sat_ff, out_sat_in;

   assign en        = !(out_vld_ff && rsp_stall);
   assign req_stall = !en;

   assign sa = '{req_seg_a_start_x, req_seg_a_start_y, req_seg_a_start_z};
   assign ea = '{req_seg_a_end_x, req_seg_a_end_y, req_seg_a_end_z};
   assign sb = '{req_seg_b_start_x, req_seg_b_start_y, req_seg_b_start_z};
   assign eb = '{req_seg_b_end_x, req_seg_b_end_y, req_seg_b_end_z};

   always_comb begin
      logic [MAG_W-1:0]  oa;
      logic [MAG_W-1:0]  ob;
      logic [WIDE_W-1:0] mid;
      logic [BIG_W:0]    r2;
      logic [QUO_W-1:0]  qf;
      logic              neg9;
      div_type           dcur;
      root_type          nxt;
      logic [RAD_W-1:0]  bitv;
      logic [RAD_W-1:0]  trial;

      fv_in = {fv_ff[FRONT_STAGES-2:0], req_valid};
      for (int k = 0; k < 3; k++) begin
         g_in[0].p1[k] = DIFF_W'(ea[k]) - DIFF_W'(sa[k]);
         g_in[0].p2[k] = DIFF_W'(eb[k]) - DIFF_W'(sb[k]);
         g_in[0].w[k]  = DIFF_W'(sb[k]) - DIFF_W'(sa[k]);
      end
      for (int s = 1; s < FRONT_STAGES; s++) begin
         g_in[s] = g_ff[s-1];
      end

      for (int k = 0; k < 3; k++) begin
         prod_in[DOT_A11][k] = $signed(g_ff[0].p1[k]) * $signed(g_ff[0].p1[k]);
         prod_in[DOT_D][k]   = $signed(g_ff[0].p1[k]) * $signed(g_ff[0].p2[k]);
         prod_in[DOT_CC][k]  = $signed(g_ff[0].p2[k]) * $signed(g_ff[0].p2[k]);
         prod_in[DOT_B1][k]  = $signed(g_ff[0].p1[k]) * $signed(g_ff[0].w[k]);
         prod_in[DOT_B2][k]  = $signed(g_ff[0].p2[k]) * $signed(g_ff[0].w[k]);
      end

      for (int j = 0; j < NUM_DOTS; j++) begin
         dot_in[j] = DOT_W'(prod_ff[j][0]) + DOT_W'(prod_ff[j][1]) + DOT_W'(prod_ff[j][2]);
         dneg_in[j] = dot_ff[j][DOT_W-1];
         mag_in[j]  = dot_ff[j][DOT_W-1] ? MAG_W'(-dot_ff[j]) : MAG_W'(dot_ff[j]);
      end

      for (int p = 0; p < NUM_PRODS; p++) begin
         oa = mag_ff[PROD_OPA[p]];
         ob = mag_ff[PROD_OPB[p]];
         pp_in[p][0] = MAG_W'(oa[HALF_W-1:0]) * MAG_W'(ob[HALF_W-1:0]);
         pp_in[p][1] = MAG_W'(oa[HALF_W-1:0]) * MAG_W'(ob[MAG_W-1:HALF_W]);
         pp_in[p][2] = MAG_W'(oa[MAG_W-1:HALF_W]) * MAG_W'(ob[HALF_W-1:0]);
         pp_in[p][3] = MAG_W'(oa[MAG_W-1:HALF_W]) * MAG_W'(ob[MAG_W-1:HALF_W]);
         pneg5_in[p] = dneg_ff[PROD_OPA[p]] ^ dneg_ff[PROD_OPB[p]];

         mid = WIDE_W'(pp_ff[p][1]) + WIDE_W'(pp_ff[p][2]);
         wide_in[p] = {pp_ff[p][3], MAG_W'(0)} + (mid << HALF_W) + WIDE_W'(pp_ff[p][0]);

         sp_in[p] = pneg6_ff[p] ? -BIG_W'(wide_ff[p]) : BIG_W'(wide_ff[p]);
      end
      pneg6_in = pneg5_ff;

      det_in    = sp_ff[0] - sp_ff[1];
      num_in[0] = sp_ff[2] - sp_ff[3];
      num_in[1] = sp_ff[4] - sp_ff[5];

      neg9    = det_ff[BIG_W-1];
      par9_in = (det_ff == '0);
      den9_in = neg9 ? BIG_W'(-det_ff) : BIG_W'(det_ff);
      for (int i = 0; i < 2; i++) begin
         nun_in[i] = neg9 ? -num_ff[i] : num_ff[i];
      end

      dvv_in = {dvv_ff[PARAM_BITS-1:0], fv_ff[FRONT_STAGES-1]};
      dv_in[0].par = par9_ff;
      dv_in[0].den = den9_ff;
      dv_in[0].geo = g_ff[FRONT_STAGES-1];
      for (int i = 0; i < 2; i++) begin
         dv_in[0].rem[i] = nun_ff[i];
         dv_in[0].quo[i] = '0;
         priority if (par9_ff || nun_ff[i][BIG_W-1] || nun_ff[i] == '0) begin
            dv_in[0].cls[i] = CLS_ZERO;
         end else if (BIG_W'(nun_ff[i]) >= den9_ff) begin
            dv_in[0].cls[i] = CLS_ONE;
         end else begin
            dv_in[0].cls[i] = CLS_DIV;
         end
      end
      for (int k = 0; k < PARAM_BITS; k++) begin
         dcur = dv_ff[k];
         for (int i = 0; i < 2; i++) begin
            r2 = {dcur.rem[i], 1'b0};
            if (r2 >= {1'b0, dcur.den}) begin
               dcur.rem[i] = BIG_W'(r2 - {1'b0, dcur.den});
               dcur.quo[i] = {dcur.quo[i][PARAM_BITS-2:0], 1'b1};
            end else begin
               dcur.rem[i] = r2[BIG_W-1:0];
               dcur.quo[i] = {dcur.quo[i][PARAM_BITS-2:0], 1'b0};
            end
         end
         dv_in[k+1] = dcur;
      end

      ev_in     = {ev_ff[E_STAGES-2:0], dvv_ff[PARAM_BITS]};
      e0_geo_in = dv_ff[PARAM_BITS].geo;
      et_in[0].par = dv_ff[PARAM_BITS].par;
      for (int i = 0; i < 2; i++) begin
         r2 = {dv_ff[PARAM_BITS].rem[i], 1'b0};
         qf = QUO_W'(dv_ff[PARAM_BITS].quo[i]);
         if (r2 >= {1'b0, dv_ff[PARAM_BITS].den}) begin
            qf = qf + QUO_W'(1);
         end
         unique case (dv_ff[PARAM_BITS].cls[i])
            CLS_ZERO: qf = '0;
            CLS_ONE:  qf = QUO_W'(1) << PARAM_BITS;
            default:  qf = qf;
         endcase
         if (i == 0) begin
            et_in[0].u = qf;
         end else begin
            et_in[0].v = qf;
         end
      end
      for (int s = 1; s < E_STAGES; s++) begin
         et_in[s] = et_ff[s-1];
      end

      for (int k = 0; k < 3; k++) begin
         mv_in[k]   = $signed({1'b0, et_ff[0].v}) * $signed(e0_geo_ff.p2[k]);
         mu_in[k]   = $signed({1'b0, et_ff[0].u}) * $signed(e0_geo_ff.p1[k]);
         e1_w_in[k] = e0_geo_ff.w[k];
         comp_in[k] = mv_ff[k] - mu_ff[k] + (CMP_W'($signed(e1_w_ff[k])) <<< PARAM_BITS);
         cmag_in[k] = comp_ff[k][CMP_W-1] ? CM_W'(-comp_ff[k]) : CM_W'(comp_ff[k]);
         sll_in[k]  = CM_W'(cmag_ff[k][CH_W-1:0]) * CM_W'(cmag_ff[k][CH_W-1:0]);
         slh_in[k]  = CM_W'(cmag_ff[k][CH_W-1:0]) * CM_W'(cmag_ff[k][CM_W-1:CH_W]);
         shh_in[k]  = CM_W'(cmag_ff[k][CM_W-1:CH_W]) * CM_W'(cmag_ff[k][CM_W-1:CH_W]);
         sq_in[k]   = {shh_ff[k], CM_W'(0)} + (SQ_W'(slh_ff[k]) << (CH_W + 1))
                      + SQ_W'(sll_ff[k]);
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

      sv_in = {sv_ff[ROOT_W-2:0], ev_ff[E_STAGES-1]};
      rt_in[0].sat  = |sum_ff[SUM_W-1:SAT_LSB];
      rt_in[0].rad  = sum_ff[SAT_LSB-1:2*PARAM_BITS];
      rt_in[0].root = '0;
      rt_in[0].tag  = et_ff[E_STAGES-1];
      nxt = rt_ff[0];
      for (int k = 0; k < ROOT_W; k++) begin
         nxt   = rt_ff[k];
         bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
         trial = nxt.root + bitv;
         if (nxt.rad >= trial) begin
            nxt.rad  = nxt.rad - trial;
            nxt.root = (nxt.root >> 1) + bitv;
         end else begin
            nxt.root = nxt.root >> 1;
         end
         if (k < ROOT_W - 1) begin
            rt_in[k+1] = nxt;
         end
      end
      out_dist_in = nxt.sat ? '1 : nxt.root[ROOT_W-1:0];
      out_u_in    = nxt.tag.u;
      out_v_in    = nxt.tag.v;
      out_par_in  = nxt.tag.par;
      out_sat_in  = nxt.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff      <= '0;
         dvv_ff     <= '0;
         ev_ff      <= '0;
         sv_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         fv_ff      <= fv_in;
         dvv_ff     <= dvv_in;
         ev_ff      <= ev_in;
         sv_ff      <= sv_in;
         out_vld_ff <= sv_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff      <= g_in;
         prod_ff   <= prod_in;
         dot_ff    <= dot_in;
         mag_ff    <= mag_in;
         dneg_ff   <= dneg_in;
         pp_ff     <= pp_in;
         pneg5_ff  <= pneg5_in;
         pneg6_ff  <= pneg6_in;
         wide_ff   <= wide_in;
         sp_ff     <= sp_in;
         det_ff    <= det_in;
         num_ff    <= num_in;
         par9_ff   <= par9_in;
         den9_ff   <= den9_in;
         nun_ff    <= nun_in;
         dv_ff     <= dv_in;
         et_ff     <= et_in;
         e0_geo_ff <= e0_geo_in;
         mv_ff     <= mv_in;
         mu_ff     <= mu_in;
         e1_w_ff   <= e1_w_in;
         comp_ff   <= comp_in;
         cmag_ff   <= cmag_in;
         sll_ff    <= sll_in;
         slh_ff    <= slh_in;
         shh_ff    <= shh_in;
         sq_ff     <= sq_in;
         sum_ff    <= sum_in;
         rt_ff     <= rt_in;
         out_dist_ff <= out_dist_in;
         out_u_ff    <= out_u_in;
         out_v_ff    <= out_v_in;
         out_par_ff  <= out_par_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_gap_distance       = out_dist_ff;
   assign rsp_param_on_a         = out_u_ff;
   assign rsp_param_on_b         = out_v_ff;
   assign rsp_lines_parallel     = out_par_ff;
   assign rsp_distance_saturated = out_sat_ff;

endmodule
